// ===== src/apt_pkg.sv =====
// shared types and constants for the allocation profile table
package apt_pkg;

    // default table geometry
    localparam int BUCKET_LG2_DEF       = 10;
    localparam int OVERFLOW_ENTRIES_DEF = 128;

    // tag value that marks the catch-all entry
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    // configuration reset values
    localparam logic        ENABLE_RST = 1'b1;
    localparam logic [31:0] BASE_RST   = 32'd0;
    localparam logic [4:0]  SHIFT_RST  = 5'd9;

    // configuration register indexes
    localparam logic [1:0] CFG_ENABLE = 2'd0;
    localparam logic [1:0] CFG_BASE   = 2'd1;
    localparam logic [1:0] CFG_SHIFT  = 2'd2;

    // request type codes, any code with the read bit set reads an entry
    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // result status codes
    typedef enum logic [2:0] {
        STS_UPDATED  = 3'd0,
        STS_UNKNOWN  = 3'd1,
        STS_CATCHALL = 3'd2,
        STS_READ     = 3'd3,
        STS_DISABLED = 3'd4
    } status_t;

    // control sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_CHECK,
        ST_EMIT
    } state_t;

    // one result item
    typedef struct packed {
        status_t            status;
        logic [31:0]        tag;
        logic signed [31:0] count;
        logic signed [31:0] bytes;
        logic               used;
    } result_t;

endpackage

// ===== src/apt_if.sv =====
// request, response and configuration channel interfaces
interface apt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] tag;
    logic [30:0] size;
    logic [10:0] entry_index;

    modport source (output valid, req_type, tag, size, entry_index, input ready);
    modport sink (input valid, req_type, tag, size, entry_index, output ready);
endinterface

interface apt_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [31:0]        entry_tag;
    logic signed [31:0] entry_count;
    logic signed [31:0] entry_bytes;
    logic               entry_used;

    modport source (output valid, status, entry_tag, entry_count, entry_bytes, entry_used,
                    input ready);
    modport sink (input valid, status, entry_tag, entry_count, entry_bytes, entry_used,
                  output ready);
endinterface

interface apt_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/alloc_profile_table_unit.sv =====
// allocation profile table: hashed counter table with chained overflow pool
// each request: idle accepts it, lookup reads the entry, check walks the chain with one more read
//   per extra hop and per new link, emit loads the output register; a read past the last entry or an
//   alloc or free while disabled skips the read; one request at a time, the next taken once emit is done
// reset: a clearing pass writes zero to all 2^BUCKET_LG2 + OVERFLOW_ENTRIES + 1 entries
//   (1153 entries by default), req.ready stays low meanwhile; cfg writes are taken throughout
module alloc_profile_table_unit #(
    parameter int BUCKET_LG2       = apt_pkg::BUCKET_LG2_DEF,
    parameter int OVERFLOW_ENTRIES = apt_pkg::OVERFLOW_ENTRIES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    apt_cfg_if.sink   cfg,
    apt_req_if.sink   req,
    apt_rsp_if.source rsp
);

    localparam int NBUCKETS = 1 << BUCKET_LG2;
    localparam int NENTRIES = NBUCKETS + OVERFLOW_ENTRIES + 1;
    localparam int CATCHALL = NBUCKETS + OVERFLOW_ENTRIES;
    localparam int IDX_W    = $clog2(NENTRIES);
    localparam int OVF_W    = $clog2(OVERFLOW_ENTRIES + 1);
    localparam int ENTRY_W  = 96 + IDX_W;

    localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(NENTRIES - 1);
    localparam logic [IDX_W-1:0] IDX_CATCHALL = IDX_W'(CATCHALL);
    localparam logic [IDX_W-1:0] IDX_POOL     = IDX_W'(NBUCKETS);
    localparam logic [OVF_W-1:0] OVF_MAX      = OVF_W'(OVERFLOW_ENTRIES);

    // configuration registers
    logic        enable_reg;
    logic [31:0] base_reg;
    logic [4:0]  shift_reg;

    // sequencer and item registers
    apt_pkg::state_t  state_reg, state_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [OVF_W-1:0] ovf_used_reg, ovf_used_next;
    logic [1:0]       item_type_reg, item_type_next;
    logic [31:0]      item_tag_reg, item_tag_next;
    logic [30:0]      item_size_reg, item_size_next;
    logic [10:0]      item_eidx_reg, item_eidx_next;
    apt_pkg::result_t res_reg, res_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    apt_pkg::result_t out_res_reg, out_res_next;

    // table memory ports
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    // fields of the entry just read
    logic [31:0]      rd_tag;
    logic [31:0]      rd_count;
    logic [31:0]      rd_bytes;
    logic [IDX_W-1:0] rd_link;

    // helpers
    logic [31:0]      tag_offset;
    logic [31:0]      tag_shifted;
    logic [IDX_W-1:0] home_idx;
    logic [31:0]      eidx_ext;
    logic             eidx_in_range;
    logic [IDX_W-1:0] link_idx;
    logic             is_read;
    logic             is_free;
    logic             hit;
    logic [31:0]      upd_tag;
    logic [31:0]      upd_count;
    logic [31:0]      upd_bytes;
    logic             out_load;

    apt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // configuration writes, always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= apt_pkg::ENABLE_RST;
            base_reg   <= apt_pkg::BASE_RST;
            shift_reg  <= apt_pkg::SHIFT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                apt_pkg::CFG_ENABLE: enable_reg <= cfg.data[0];
                apt_pkg::CFG_BASE:   base_reg   <= cfg.data;
                apt_pkg::CFG_SHIFT:  shift_reg  <= cfg.data[4:0];
                default:             ;
            endcase
        end
    end

    // entry decode and derived values
    assign {rd_tag, rd_count, rd_bytes, rd_link} = rd_data;

    assign tag_offset    = item_tag_reg - base_reg;
    assign tag_shifted   = tag_offset >> shift_reg;
    assign home_idx      = IDX_W'(tag_shifted[BUCKET_LG2-1:0]);
    assign eidx_ext      = 32'(item_eidx_reg);
    assign eidx_in_range = eidx_ext < 32'(NENTRIES);
    assign link_idx      = (32'(rd_link) >= 32'(NENTRIES)) ? IDX_CATCHALL : rd_link;

    assign is_read = (item_type_reg & apt_pkg::REQ_READ) != 2'd0;
    assign is_free = item_type_reg == apt_pkg::REQ_FREE;
    assign hit     = (rd_tag == item_tag_reg) || (rd_tag == apt_pkg::ALL_ONES);

    // counter update of the current entry
    assign upd_tag   = hit ? rd_tag : item_tag_reg;
    assign upd_count = is_free ? rd_count - 32'd1 : rd_count + 32'd1;
    assign upd_bytes = is_free ? rd_bytes - {1'b0, item_size_reg}
                               : rd_bytes + {1'b0, item_size_reg};

    assign req.ready = state_reg == apt_pkg::ST_IDLE;
    assign out_load  = (state_reg == apt_pkg::ST_EMIT) && (!out_valid_reg || rsp.ready);

    // sequencer: clear, look up, walk chain, update or read entry, emit
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cur_next       = cur_reg;
        ovf_used_next  = ovf_used_reg;
        item_type_next = item_type_reg;
        item_tag_next  = item_tag_reg;
        item_size_next = item_size_reg;
        item_eidx_next = item_eidx_reg;
        res_next       = res_reg;
        wr_en          = 1'b0;
        wr_addr        = cur_reg;
        wr_data        = rd_data;
        rd_en          = 1'b0;
        rd_addr        = cur_reg;

        case (state_reg)
            apt_pkg::ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '0;
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_LAST)
                begin
                    state_next = apt_pkg::ST_IDLE;
                end
            end

            apt_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    item_type_next = req.req_type;
                    item_tag_next  = req.tag;
                    item_size_next = req.size;
                    item_eidx_next = req.entry_index;
                    state_next     = apt_pkg::ST_LOOKUP;
                end
            end

            apt_pkg::ST_LOOKUP:
            begin
                res_next = '{status: apt_pkg::STS_READ, tag: '0, count: '0,
                             bytes: '0, used: 1'b0};
                if (is_read)
                begin
                    if (eidx_in_range)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = eidx_ext[IDX_W-1:0];
                        cur_next   = eidx_ext[IDX_W-1:0];
                        state_next = apt_pkg::ST_CHECK;
                    end
                    else
                    begin
                        state_next = apt_pkg::ST_EMIT;
                    end
                end
                else if (!enable_reg)
                begin
                    res_next.status = apt_pkg::STS_DISABLED;
                    state_next      = apt_pkg::ST_EMIT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = home_idx;
                    cur_next   = home_idx;
                    state_next = apt_pkg::ST_CHECK;
                end
            end

            apt_pkg::ST_CHECK:
            begin
                if (is_read)
                begin
                    res_next = '{status: apt_pkg::STS_READ, tag: rd_tag, count: rd_count,
                                 bytes: rd_bytes, used: |{rd_tag, rd_count, rd_bytes}};
                    state_next = apt_pkg::ST_EMIT;
                end
                else if (!hit && rd_link != '0)
                begin
                    // follow the chain
                    rd_en    = 1'b1;
                    rd_addr  = link_idx;
                    cur_next = link_idx;
                end
                else if (!hit && is_free)
                begin
                    res_next = '{status: apt_pkg::STS_UNKNOWN, tag: '0, count: '0,
                                 bytes: '0, used: 1'b0};
                    state_next = apt_pkg::ST_EMIT;
                end
                else if (!hit && rd_tag != '0)
                begin
                    // chain end taken: link a new overflow entry or the catch-all
                    if (ovf_used_reg < OVF_MAX)
                    begin
                        cur_next      = IDX_POOL + IDX_W'(ovf_used_reg);
                        ovf_used_next = ovf_used_reg + OVF_W'(1);
                    end
                    else
                    begin
                        cur_next      = IDX_CATCHALL;
                        item_tag_next = apt_pkg::ALL_ONES;
                    end
                    wr_en   = 1'b1;
                    wr_addr = cur_reg;
                    wr_data = {rd_tag, rd_count, rd_bytes, cur_next};
                    rd_en   = 1'b1;
                    rd_addr = cur_next;
                end
                else
                begin
                    // matching entry, or empty chain end taken over
                    wr_en   = 1'b1;
                    wr_addr = cur_reg;
                    wr_data = {upd_tag, upd_count, upd_bytes, rd_link};
                    res_next = '{status: (cur_reg == IDX_CATCHALL) ? apt_pkg::STS_CATCHALL
                                                                   : apt_pkg::STS_UPDATED,
                                 tag: upd_tag, count: upd_count, bytes: upd_bytes,
                                 used: |{upd_tag, upd_count, upd_bytes}};
                    state_next = apt_pkg::ST_EMIT;
                end
            end

            apt_pkg::ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = apt_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = apt_pkg::ST_IDLE;
            end
        endcase
    end

    // output register next value
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res_reg;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= apt_pkg::ST_CLEAR;
            clr_reg       <= '0;
            ovf_used_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            ovf_used_reg  <= ovf_used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        item_type_reg <= item_type_next;
        item_tag_reg  <= item_tag_next;
        item_size_reg <= item_size_next;
        item_eidx_reg <= item_eidx_next;
        res_reg       <= res_next;
        out_res_reg   <= out_res_next;
    end

    // response channel
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_res_reg.status;
    assign rsp.entry_tag   = out_res_reg.tag;
    assign rsp.entry_count = out_res_reg.count;
    assign rsp.entry_bytes = out_res_reg.bytes;
    assign rsp.entry_used  = out_res_reg.used;

    // overflow pool never hands out more entries than it holds
    a_ovf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_used_reg <= OVF_MAX)
    else $error("overflow pool count out of range");

    // table reads stay inside the table
    a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (32'(rd_addr) < 32'(NENTRIES)))
    else $error("table read beyond last entry");

    // a write and a read in the same cycle never touch the same entry
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write of one entry in one cycle");

    // a claimed chain link is always followed by a check of the new entry
    a_claim_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == apt_pkg::ST_CHECK && wr_en && rd_en) |=>
            (state_reg == apt_pkg::ST_CHECK && cur_reg != $past(cur_reg)))
    else $error("claimed entry not checked");

endmodule

// ===== src/apt_ram.sv =====
// generic single write port, single read port ram with registered read
module apt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
